// ===== sv/utc_local_time_dst_convert_core_macros.svh =====
// ============================================================================
// UTC / local time converter assertion macros
// Shared concurrent assertion forms for the converter's checker.
// ============================================================================
`ifndef UTC_LOCAL_TIME_DST_CONVERT_CORE_MACROS_SVH
`define UTC_LOCAL_TIME_DST_CONVERT_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UTCDST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define UTCDST_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/utcdst_pkg.sv =====
// ============================================================================
// UTC / local time converter package
// Types, register codes and division constants shared by the converter.
// ============================================================================
`default_nettype none

package utcdst_pkg;

    // Time base and offset widths.
    localparam int TIME_BITS = 34;
    localparam int CFG_BITS  = 17;
    localparam int SUM_BITS  = TIME_BITS + 2;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DST_RULE      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STD_OFFSET    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUMMER_OFFSET = 2'd2;

    // Daylight saving rule codes; any other code means no daylight saving.
    localparam logic [1:0] RULE_EU = 2'd1;
    localparam logic [1:0] RULE_US = 2'd2;

    // Conversion direction.
    localparam logic OP_TO_UTC = 1'b1;

    // Months that bound the daylight saving windows.
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    // Cycles from an accepted start to the done strobe.
    localparam int PIPE_DEPTH = 12;

    // Day split: 86400 = 675 << 7, so days = (t >> 7) / 675 by reciprocal.
    localparam int DAY_SHIFT       = 7;
    localparam int DAY_BITS        = 18;
    localparam int DAY_RECIP_SHIFT = 37;
    localparam logic [9:0]  DAY_ODD   = 10'd675;
    localparam logic [27:0] DAY_RECIP = 28'd203613265;

    // Seconds of day at which hour one and hour two begin.
    localparam logic [16:0] SEC_HOUR1 = 17'd3600;
    localparam logic [16:0] SEC_HOUR2 = 17'd7200;

    // Epoch shift to 0000-03-01 and the bases of the possible 400-year eras.
    localparam logic [19:0] EPOCH_DAYS = 20'd719468;
    localparam logic [19:0] ERA_BASE4  = 20'd584388;
    localparam logic [19:0] ERA_BASE5  = 20'd730485;
    localparam logic [19:0] ERA_BASE6  = 20'd876582;

    // Century boundaries within an era (day of era).
    localparam logic [17:0] DOE_CENT1 = 18'd36524;
    localparam logic [17:0] DOE_CENT2 = 18'd73048;
    localparam logic [17:0] DOE_CENT3 = 18'd109572;
    localparam logic [17:0] DOE_CENT4 = 18'd146096;

    // Reciprocals for the small constant divisions.
    localparam int WEEK_SHIFT = 21;
    localparam logic [18:0] WEEK_RECIP = 19'd299594;
    localparam int LEAP_SHIFT = 29;
    localparam logic [18:0] LEAP_RECIP = 19'd367720;
    localparam int YEAR_SHIFT = 27;
    localparam logic [18:0] YEAR_RECIP = 19'd367720;
    localparam int MP_SHIFT = 19;
    localparam logic [11:0] MP_RECIP = 12'd3427;
    localparam int FIVE_SHIFT = 14;
    localparam logic [11:0] FIVE_RECIP = 12'd3277;

    // One input item.
    typedef struct packed {
        logic                 operation;
        logic [TIME_BITS-1:0] time_value;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [TIME_BITS-1:0] converted_time;
        logic                 dst_active;
        logic                 range_clipped;
    } out_item_t;

    // Position of the decision time within its day.
    typedef struct packed {
        logic ge_one;
        logic ge_two;
    } hour_flags_t;

    // Calendar fields handed from the date pipeline to the rule logic.
    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        hour_flags_t hour;
    } date_t;

    // Remainder by seven of a value below 64: quotient is (v * 74) >> 9.
    function automatic logic [2:0] mod7_small(input logic [5:0] v);
        logic [12:0] prod;
        logic [5:0]  rem;
        prod = 13'(v) * 13'd74;
        rem  = v - (6'(prod[12:9]) * 6'd7);
        return rem[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/utcdst_calendar.sv =====
// ============================================================================
// UTC / local time converter calendar pipeline
// Nine-stage breakdown of a time into month, day of month, weekday and hour.
// ============================================================================
`default_nettype none

module utcdst_calendar (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic [utcdst_pkg::TIME_BITS-1:0]     in_time,
    input  wire utcdst_pkg::in_item_t                 in_side,
    output logic                                      out_valid,
    output utcdst_pkg::date_t                         out_date,
    output utcdst_pkg::in_item_t                      out_side
);

    // Valid bits for the nine stages.
    logic [8:0] valid_reg;

    // Sideband item that travels with each stage.
    utcdst_pkg::in_item_t side_reg [9];

    // Stage 1: days by reciprocal.
    logic [54:0]                        c1_prod_reg;
    logic [utcdst_pkg::TIME_BITS-1:0]   c1_time_reg;
    // Stage 2: hour flags, weekday base, day of era.
    logic [17:0]                        c2_y_reg;
    logic [17:0]                        c2_doe_reg;
    utcdst_pkg::hour_flags_t            c2_hour_reg;
    // Stage 3: weekday and leap-day products.
    logic [36:0]                        c3_wprod_reg;
    logic [36:0]                        c3_lprod_reg;
    logic [17:0]                        c3_y_reg;
    logic [17:0]                        c3_doe_reg;
    logic [2:0]                         c3_cent_reg;
    logic                               c3_era_end_reg;
    utcdst_pkg::hour_flags_t            c3_hour_reg;
    // Stage 4: weekday and leap-adjusted day count.
    logic [2:0]                         c4_wday_reg;
    logic [17:0]                        c4_n_reg;
    logic [17:0]                        c4_doe_reg;
    utcdst_pkg::hour_flags_t            c4_hour_reg;
    // Stage 5: year of era product.
    logic [36:0]                        c5_yprod_reg;
    logic [2:0]                         c5_wday_reg;
    logic [17:0]                        c5_doe_reg;
    utcdst_pkg::hour_flags_t            c5_hour_reg;
    // Stage 6: day of year.
    logic [8:0]                         c6_doy_reg;
    logic [2:0]                         c6_wday_reg;
    utcdst_pkg::hour_flags_t            c6_hour_reg;
    // Stage 7: month product.
    logic [22:0]                        c7_mprod_reg;
    logic [8:0]                         c7_doy_reg;
    logic [2:0]                         c7_wday_reg;
    utcdst_pkg::hour_flags_t            c7_hour_reg;
    // Stage 8: month start product.
    logic [22:0]                        c8_dprod_reg;
    logic [3:0]                         c8_mp_reg;
    logic [8:0]                         c8_doy_reg;
    logic [2:0]                         c8_wday_reg;
    utcdst_pkg::hour_flags_t            c8_hour_reg;
    // Stage 9: output date.
    utcdst_pkg::date_t                  c9_date_reg;

    // Combinational values between stages.
    logic [26:0] c2_x;
    logic [17:0] c2_days;
    logic [26:0] c2_day_base;
    logic [16:0] c2_secs;
    logic [19:0] c2_z;
    logic [19:0] c2_era_base;
    logic [15:0] c4_wq;
    logic [17:0] c4_wrem;
    logic [7:0]  c4_q1460;
    logic [18:0] c4_n;
    logic [8:0]  c6_yoe;
    logic [1:0]  c6_cent;
    logic [18:0] c6_ybase;
    logic [18:0] c6_doy;
    logic [10:0] c7_v;
    logic [3:0]  c8_mp;
    logic [10:0] c8_w;
    logic [8:0]  c9_q5;
    logic [8:0]  c9_mday;
    logic [3:0]  c9_month;

    // Valid bits advance every cycle; the pipeline never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    // Sideband shift line.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int i = 1; i < 9; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Stage 2 logic: whole days, seconds of day and day of era.
    always_comb
    begin
        c2_x        = c1_time_reg[utcdst_pkg::TIME_BITS-1:utcdst_pkg::DAY_SHIFT];
        c2_days     = c1_prod_reg[utcdst_pkg::DAY_RECIP_SHIFT +: utcdst_pkg::DAY_BITS];
        c2_day_base = 27'(c2_days) * 27'(utcdst_pkg::DAY_ODD);
        c2_secs     = {10'(c2_x - c2_day_base),
                       c1_time_reg[utcdst_pkg::DAY_SHIFT-1:0]};
        c2_z        = 20'(c2_days) + utcdst_pkg::EPOCH_DAYS;
        // The era is one of three, since the day count is never negative.
        if (c2_z >= utcdst_pkg::ERA_BASE6)
        begin
            c2_era_base = utcdst_pkg::ERA_BASE6;
        end
        else if (c2_z >= utcdst_pkg::ERA_BASE5)
        begin
            c2_era_base = utcdst_pkg::ERA_BASE5;
        end
        else
        begin
            c2_era_base = utcdst_pkg::ERA_BASE4;
        end
    end

    // Stage 4 logic: weekday remainder and leap-adjusted day count.
    always_comb
    begin
        c4_wq    = c3_wprod_reg[utcdst_pkg::WEEK_SHIFT +: 16];
        c4_wrem  = c3_y_reg - (18'(c4_wq) * 18'd7);
        c4_q1460 = c3_lprod_reg[utcdst_pkg::LEAP_SHIFT +: 8];
        c4_n     = 19'(c3_doe_reg) - 19'(c4_q1460) + 19'(c3_cent_reg)
                   - 19'(c3_era_end_reg);
    end

    // Stage 6 logic: year of era and day of year (from March 1).
    always_comb
    begin
        c6_yoe   = c5_yprod_reg[utcdst_pkg::YEAR_SHIFT +: 9];
        c6_cent  = 2'(c6_yoe >= 9'd100) + 2'(c6_yoe >= 9'd200) + 2'(c6_yoe >= 9'd300);
        c6_ybase = (19'(c6_yoe) * 19'd365) + 19'(c6_yoe[8:2]) - 19'(c6_cent);
        c6_doy   = 19'(c5_doe_reg) - c6_ybase;
    end

    // Stage 7 and 8 logic: month index from day of year.
    always_comb
    begin
        c7_v  = (11'(c6_doy_reg) * 11'd5) + 11'd2;
        c8_mp = c7_mprod_reg[utcdst_pkg::MP_SHIFT +: 4];
        c8_w  = (11'(c8_mp) * 11'd153) + 11'd2;
    end

    // Stage 9 logic: day of month and calendar month.
    always_comb
    begin
        c9_q5   = c8_dprod_reg[utcdst_pkg::FIVE_SHIFT +: 9];
        c9_mday = c8_doy_reg - c9_q5 + 9'd1;
        if (c8_mp_reg < 4'd10)
        begin
            c9_month = c8_mp_reg + 4'd3;
        end
        else
        begin
            c9_month = c8_mp_reg - 4'd9;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        // Stage 1
        c1_prod_reg <= 55'(in_time[utcdst_pkg::TIME_BITS-1:utcdst_pkg::DAY_SHIFT])
                       * 55'(utcdst_pkg::DAY_RECIP);
        c1_time_reg <= in_time;

        // Stage 2
        c2_y_reg           <= c2_days + 18'd4;
        c2_doe_reg         <= 18'(c2_z - c2_era_base);
        c2_hour_reg.ge_one <= (c2_secs >= utcdst_pkg::SEC_HOUR1);
        c2_hour_reg.ge_two <= (c2_secs >= utcdst_pkg::SEC_HOUR2);

        // Stage 3
        c3_wprod_reg   <= 37'(c2_y_reg) * 37'(utcdst_pkg::WEEK_RECIP);
        c3_lprod_reg   <= 37'(c2_doe_reg) * 37'(utcdst_pkg::LEAP_RECIP);
        c3_y_reg       <= c2_y_reg;
        c3_doe_reg     <= c2_doe_reg;
        c3_cent_reg    <= 3'(c2_doe_reg >= utcdst_pkg::DOE_CENT1)
                          + 3'(c2_doe_reg >= utcdst_pkg::DOE_CENT2)
                          + 3'(c2_doe_reg >= utcdst_pkg::DOE_CENT3)
                          + 3'(c2_doe_reg >= utcdst_pkg::DOE_CENT4);
        c3_era_end_reg <= (c2_doe_reg >= utcdst_pkg::DOE_CENT4);
        c3_hour_reg    <= c2_hour_reg;

        // Stage 4
        c4_wday_reg <= c4_wrem[2:0];
        c4_n_reg    <= c4_n[17:0];
        c4_doe_reg  <= c3_doe_reg;
        c4_hour_reg <= c3_hour_reg;

        // Stage 5
        c5_yprod_reg <= 37'(c4_n_reg) * 37'(utcdst_pkg::YEAR_RECIP);
        c5_wday_reg  <= c4_wday_reg;
        c5_doe_reg   <= c4_doe_reg;
        c5_hour_reg  <= c4_hour_reg;

        // Stage 6
        c6_doy_reg  <= c6_doy[8:0];
        c6_wday_reg <= c5_wday_reg;
        c6_hour_reg <= c5_hour_reg;

        // Stage 7
        c7_mprod_reg <= 23'(c7_v) * 23'(utcdst_pkg::MP_RECIP);
        c7_doy_reg   <= c6_doy_reg;
        c7_wday_reg  <= c6_wday_reg;
        c7_hour_reg  <= c6_hour_reg;

        // Stage 8
        c8_dprod_reg <= 23'(c8_w) * 23'(utcdst_pkg::FIVE_RECIP);
        c8_mp_reg    <= c8_mp;
        c8_doy_reg   <= c7_doy_reg;
        c8_wday_reg  <= c7_wday_reg;
        c8_hour_reg  <= c7_hour_reg;

        // Stage 9
        c9_date_reg.month <= c9_month;
        c9_date_reg.mday  <= c9_mday[4:0];
        c9_date_reg.wday  <= c8_wday_reg;
        c9_date_reg.hour  <= c8_hour_reg;
    end

    assign out_valid = valid_reg[8];
    assign out_date  = c9_date_reg;
    assign out_side  = side_reg[8];

endmodule

`default_nettype wire

// ===== sv/utc_local_time_dst_convert_core.sv =====
// ============================================================================
// UTC / local time converter with daylight saving rules
// Converts UTC to local time or back under an EU or US daylight rule.
// ============================================================================
// Pipeline: decision time register, calendar breakdown, daylight decision, output register.
// Throughput: one conversion per cycle; busy is low whenever reset is released.
// Most of the depth is the calendar breakdown, which spreads its multiplies over its stages.
// Reset: rst_n is asynchronous and clears the valid bits, done and the
// configuration registers (no daylight rule, zero offsets); busy is high in reset.
// Results cannot be held off by the receiver.
`default_nettype none

module utc_local_time_dst_convert_core (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire utcdst_pkg::in_item_t                      request,
    output logic                                           done,
    output utcdst_pkg::out_item_t                          result,
    input  wire logic                                      cfg_write,
    input  wire logic [utcdst_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [utcdst_pkg::CFG_BITS-1:0]           cfg_data
);

    // Configuration registers.
    logic [1:0]                         dst_rule_reg;
    logic [utcdst_pkg::CFG_BITS-1:0]    std_offset_reg;
    logic [utcdst_pkg::CFG_BITS-1:0]    summer_offset_reg;

    // Stage 1: decision time.
    logic                               s1_valid_reg;
    logic [utcdst_pkg::TIME_BITS-1:0]   s1_time_reg;
    utcdst_pkg::in_item_t               s1_side_reg;
    logic [utcdst_pkg::TIME_BITS-1:0]   s1_time_next;
    logic [utcdst_pkg::SUM_BITS-1:0]    std_ext;
    logic [utcdst_pkg::SUM_BITS-1:0]    cand_diff;
    logic                               accept;

    // Calendar pipeline outputs.
    logic                               cal_valid;
    utcdst_pkg::date_t                  cal_date;
    utcdst_pkg::in_item_t               cal_side;

    // Stage 11: daylight decision.
    logic                               s11_valid_reg;
    logic                               s11_dst_reg;
    utcdst_pkg::in_item_t               s11_side_reg;
    logic                               s11_dst_next;
    logic [5:0]                         eu_arg;
    logic [4:0]                         eu_sun;
    logic [5:0]                         us_arg;
    logic [2:0]                         us_first;
    logic [4:0]                         us_sun;

    // Stage 12: offset and saturation.
    logic                               done_reg;
    utcdst_pkg::out_item_t              result_reg;
    utcdst_pkg::out_item_t              result_next;
    logic [utcdst_pkg::CFG_BITS-1:0]    off_sel;
    logic [utcdst_pkg::SUM_BITS-1:0]    off_ext;
    logic [utcdst_pkg::SUM_BITS-1:0]    off_delta;
    logic [utcdst_pkg::SUM_BITS-1:0]    out_sum;

    // The pipeline takes a transfer every cycle outside reset.
    assign busy   = ~rst_n;
    assign accept = start & ~busy;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_rule_reg      <= '0;
            std_offset_reg    <= '0;
            summer_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                utcdst_pkg::REG_DST_RULE:      dst_rule_reg      <= cfg_data[1:0];
                utcdst_pkg::REG_STD_OFFSET:    std_offset_reg    <= cfg_data;
                utcdst_pkg::REG_SUMMER_OFFSET: summer_offset_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Local to UTC decides daylight saving on the time minus the standard
    // offset, clamped to the time range.
    always_comb
    begin
        std_ext = {{(utcdst_pkg::SUM_BITS-utcdst_pkg::CFG_BITS){std_offset_reg[utcdst_pkg::CFG_BITS-1]}},
                   std_offset_reg};
        cand_diff = {{(utcdst_pkg::SUM_BITS-utcdst_pkg::TIME_BITS){1'b0}}, request.time_value}
                    - std_ext;
        if (request.operation != utcdst_pkg::OP_TO_UTC)
        begin
            s1_time_next = request.time_value;
        end
        else if (cand_diff[utcdst_pkg::SUM_BITS-1])
        begin
            s1_time_next = '0;
        end
        else if (cand_diff[utcdst_pkg::TIME_BITS])
        begin
            s1_time_next = utcdst_pkg::TIME_MAX;
        end
        else
        begin
            s1_time_next = cand_diff[utcdst_pkg::TIME_BITS-1:0];
        end
    end

    // Stage 1 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_time_reg <= s1_time_next;
        s1_side_reg <= request;
    end

    // Calendar breakdown of the decision time.
    utcdst_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_time   (s1_time_reg),
        .in_side   (s1_side_reg),
        .out_valid (cal_valid),
        .out_date  (cal_date),
        .out_side  (cal_side)
    );

    // Daylight saving decision from month, day of month, weekday and hour.
    always_comb
    begin
        // European rule: last Sunday of the month.
        eu_arg = 6'(cal_date.wday) + 6'd31 - 6'(cal_date.mday);
        eu_sun = 5'd31 - 5'(utcdst_pkg::mod7_small(eu_arg));

        // US rule: weekday of the first of the month, then its first Sunday.
        us_arg   = 6'(cal_date.wday) + 6'd36 - 6'(cal_date.mday);
        us_first = utcdst_pkg::mod7_small(us_arg);
        if (us_first == 3'd0)
        begin
            us_sun = 5'd1;
        end
        else
        begin
            us_sun = 5'd8 - 5'(us_first);
        end
        // March uses the second Sunday.
        if (cal_date.month == utcdst_pkg::MONTH_MAR)
        begin
            us_sun = us_sun + 5'd7;
        end

        s11_dst_next = 1'b0;
        unique case (dst_rule_reg)
            utcdst_pkg::RULE_EU:
            begin
                if (cal_date.month < utcdst_pkg::MONTH_MAR
                    || cal_date.month > utcdst_pkg::MONTH_OCT)
                begin
                    s11_dst_next = 1'b0;
                end
                else if (cal_date.month > utcdst_pkg::MONTH_MAR
                         && cal_date.month < utcdst_pkg::MONTH_OCT)
                begin
                    s11_dst_next = 1'b1;
                end
                else if (cal_date.month == utcdst_pkg::MONTH_MAR)
                begin
                    s11_dst_next = (cal_date.mday != eu_sun) ? (cal_date.mday > eu_sun)
                                                             : cal_date.hour.ge_one;
                end
                else
                begin
                    s11_dst_next = (cal_date.mday != eu_sun) ? (cal_date.mday < eu_sun)
                                                             : !cal_date.hour.ge_one;
                end
            end
            utcdst_pkg::RULE_US:
            begin
                if (cal_date.month < utcdst_pkg::MONTH_MAR
                    || cal_date.month > utcdst_pkg::MONTH_NOV)
                begin
                    s11_dst_next = 1'b0;
                end
                else if (cal_date.month > utcdst_pkg::MONTH_MAR
                         && cal_date.month < utcdst_pkg::MONTH_NOV)
                begin
                    s11_dst_next = 1'b1;
                end
                else if (cal_date.month == utcdst_pkg::MONTH_MAR)
                begin
                    s11_dst_next = (cal_date.mday != us_sun) ? (cal_date.mday > us_sun)
                                                             : cal_date.hour.ge_two;
                end
                else
                begin
                    s11_dst_next = (cal_date.mday != us_sun) ? (cal_date.mday < us_sun)
                                                             : !cal_date.hour.ge_two;
                end
            end
            default:
            begin
                s11_dst_next = 1'b0;
            end
        endcase
    end

    // Stage 11 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s11_valid_reg <= 1'b0;
        end
        else
        begin
            s11_valid_reg <= cal_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s11_dst_reg  <= s11_dst_next;
        s11_side_reg <= cal_side;
    end

    // Apply the selected offset in the requested direction and saturate.
    always_comb
    begin
        off_sel = s11_dst_reg ? summer_offset_reg : std_offset_reg;
        off_ext = {{(utcdst_pkg::SUM_BITS-utcdst_pkg::CFG_BITS){off_sel[utcdst_pkg::CFG_BITS-1]}},
                   off_sel};
        off_delta = (s11_side_reg.operation == utcdst_pkg::OP_TO_UTC) ? (~off_ext + 1'b1)
                                                                      : off_ext;
        out_sum = {{(utcdst_pkg::SUM_BITS-utcdst_pkg::TIME_BITS){1'b0}},
                   s11_side_reg.time_value} + off_delta;

        result_next.dst_active = s11_dst_reg;
        if (out_sum[utcdst_pkg::SUM_BITS-1])
        begin
            result_next.converted_time = '0;
            result_next.range_clipped  = 1'b1;
        end
        else if (out_sum[utcdst_pkg::TIME_BITS])
        begin
            result_next.converted_time = utcdst_pkg::TIME_MAX;
            result_next.range_clipped  = 1'b1;
        end
        else
        begin
            result_next.converted_time = out_sum[utcdst_pkg::TIME_BITS-1:0];
            result_next.range_clipped  = 1'b0;
        end
    end

    // Output registers: each result is shown for exactly one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s11_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sv/utcdst_checker.sv =====
// ============================================================================
// UTC / local time converter port checker
// Watches the converter's ports for latency, saturation and reset behavior.
// ============================================================================
`default_nettype none

`include "utc_local_time_dst_convert_core_macros.svh"

module utcdst_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire utcdst_pkg::out_item_t result
);

    // Every accepted transfer produces a result after the fixed latency.
    `UTCDST_ASSERT(a_accept_to_done, clk, rst_n, ((start && !busy) |-> ##12 done), "accepted transfer did not complete after the pipeline latency")

    // No result appears without a transfer accepted one latency earlier.
    `UTCDST_ASSERT(a_done_has_source, clk, rst_n, (done |-> $past(start && !busy, utcdst_pkg::PIPE_DEPTH)), "result without a matching accepted transfer")

    // A clipped result sits exactly at one end of the time range.
    `UTCDST_ASSERT(a_clip_at_bound, clk, rst_n, ((done && result.range_clipped) |-> (result.converted_time == '0 || result.converted_time == utcdst_pkg::TIME_MAX)), "clipped result is not at a range bound")

    // In reset the block refuses transfers and shows no result.
    `UTCDST_ASSERT_ALWAYS(a_reset_quiet, clk, (!rst_n |-> (busy && !done)), "block not quiet during reset")

endmodule

bind utc_local_time_dst_convert_core utcdst_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ===== verif/utc_local_time_dst_convert_core_checker.sv =====
// ----------------------------------------------------------------------------
// UTC / local time converter checker
// Watches the request, result and register write channels of the converter.
// It keeps its own copy of the registers, computes each expected result and
// compares every result against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utc_local_time_dst_convert_core_checker
    import utcdst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  in_item_t                  request,
    input  logic                      done,
    input  out_item_t                 result,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    output int                        fail_count,
    output int                        pending
);

    localparam longint TIME_TOP = (64'sd1 <<< TIME_BITS) - 1;
    localparam longint SECS_DAY = 86400;
    localparam longint SECS_HOUR = 3600;

    // Register copies.
    logic [1:0] rule_copy;
    longint     std_copy;
    longint     summer_copy;

    // Results still owed by the converter, oldest first.
    out_item_t  owed_results[$];

    // Add a signed offset and clamp the sum into the time range.
    function automatic logic [TIME_BITS-1:0] shift_saturate(input longint t,
                                                            input longint off,
                                                            output logic clip);
        longint total;
        total = t + off;
        clip = 1'b0;
        if (total < 0) begin
            clip = 1'b1;
            return '0;
        end
        if (total > TIME_TOP) begin
            clip = 1'b1;
            return TIME_MAX;
        end
        return total[TIME_BITS-1:0];
    endfunction

    // Decide whether the daylight window is open at UTC time t.
    function automatic logic dst_window_open(input longint t, input logic [1:0] rule);
        longint day_no;
        longint sec_of_day;
        longint z;
        longint era;
        longint doe;
        longint yoe;
        longint doy;
        longint mp;
        int     hr;
        int     wd;
        int     md;
        int     mon;
        int     first_wd;
        int     sunday;
        if (rule != RULE_EU && rule != RULE_US)
            return 1'b0;

        day_no     = t / SECS_DAY;
        sec_of_day = t % SECS_DAY;
        hr         = int'(sec_of_day / SECS_HOUR);
        wd         = int'((day_no + 4) % 7);

        // Civil date from a day count, years starting in March.
        z   = day_no + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        md  = int'(doy - (153 * mp + 2) / 5 + 1);
        mon = (mp < 10) ? int'(mp + 3) : int'(mp - 9);

        if (rule == RULE_EU) begin
            if (mon < 3 || mon > 10)
                return 1'b0;
            if (mon > 3 && mon < 10)
                return 1'b1;
            // Both bounding months have 31 days, so count back from the 31st.
            sunday = 31 - ((wd + 31 - md) % 7);
            if (mon == 3)
                return (md != sunday) ? (md > sunday) : (hr >= 1);
            return (md != sunday) ? (md < sunday) : (hr < 1);
        end

        if (mon < 3 || mon > 11)
            return 1'b0;
        if (mon > 3 && mon < 11)
            return 1'b1;
        first_wd = (wd + 35 - (md - 1)) % 7;
        sunday   = 1 + (7 - first_wd) % 7;
        if (mon == 3) begin
            sunday = sunday + 7;
            return (md != sunday) ? (md > sunday) : (hr >= 2);
        end
        return (md != sunday) ? (md < sunday) : (hr < 2);
    endfunction

    // Expected result of one request under the current registers.
    function automatic out_item_t convert_expected(input in_item_t req);
        out_item_t            res;
        longint               t;
        longint               off;
        logic [TIME_BITS-1:0] probe;
        logic                 ignored;
        logic                 clip;
        logic                 dst;
        t = longint'(req.time_value);
        if (req.operation == OP_TO_UTC) begin
            // The daylight decision looks at the standard-time estimate of UTC.
            probe = shift_saturate(t, -std_copy, ignored);
            dst   = dst_window_open(longint'(probe), rule_copy);
            off   = dst ? summer_copy : std_copy;
            res.converted_time = shift_saturate(t, -off, clip);
        end else begin
            dst = dst_window_open(t, rule_copy);
            off = dst ? summer_copy : std_copy;
            res.converted_time = shift_saturate(t, off, clip);
        end
        res.dst_active    = dst;
        res.range_clipped = clip;
        return res;
    endfunction

    // Track writes, predict accepted requests and check results.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t owed;
        if (!rst_n) begin
            rule_copy   = '0;
            std_copy    = 0;
            summer_copy = 0;
            owed_results.delete();
            fail_count  = 0;
            pending     = 0;
        end else begin
            if (done) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with no request outstanding: time %0d",
                           result.converted_time);
                    fail_count = fail_count + 1;
                end else begin
                    owed = owed_results.pop_front();
                    if (result.converted_time !== owed.converted_time) begin
                        $error("converted_time mismatch: expected %0d, actual %0d",
                               owed.converted_time, result.converted_time);
                        fail_count = fail_count + 1;
                    end
                    if (result.dst_active !== owed.dst_active) begin
                        $error("dst_active mismatch: expected %0b, actual %0b",
                               owed.dst_active, result.dst_active);
                        fail_count = fail_count + 1;
                    end
                    if (result.range_clipped !== owed.range_clipped) begin
                        $error("range_clipped mismatch: expected %0b, actual %0b",
                               owed.range_clipped, result.range_clipped);
                        fail_count = fail_count + 1;
                    end
                end
            end

            if (start && !busy)
                owed_results.push_back(convert_expected(request));

            if (cfg_write) begin
                case (cfg_index)
                    REG_DST_RULE:      rule_copy   = cfg_data[1:0];
                    REG_STD_OFFSET:    std_copy    = longint'($signed(cfg_data));
                    REG_SUMMER_OFFSET: summer_copy = longint'($signed(cfg_data));
                    default:           ;
                endcase
            end

            pending = owed_results.size();
        end
    end

endmodule

// ===== verif/utc_local_time_dst_convert_core_test.sv =====
// ----------------------------------------------------------------------------
// UTC / local time converter testbench
// Drives conversion requests and register writes into the converter through
// several register settings: no rule, the EU and US rules, the unused rule
// code, extreme offsets. The first settings get directed transfers at daylight
// boundaries, range ends or the spare index; all get random bursts mostly aimed
// at the transition months. A checker beside the converter predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utc_local_time_dst_convert_core_test;

    import utcdst_pkg::*;

    localparam longint TIME_TOP     = (64'sd1 <<< TIME_BITS) - 1;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     NUM_PHASES   = 10;
    localparam int     ITEMS_PHASE  = 90;
    localparam logic   OP_TO_LOCAL  = 1'b0;
    localparam logic [1:0] RULE_NONE   = 2'd0;
    localparam logic [1:0] RULE_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    in_item_t                  request;
    logic                      done;
    out_item_t                 result;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;
    int                        fail_count;
    int                        pending;
    int                        cycle_count = 0;

    // Offsets currently programmed, used to aim local-time requests.
    int                        std_now;
    int                        summer_now;

    logic [1:0]                phase_rule[NUM_PHASES];
    int                        phase_std[NUM_PHASES];
    int                        phase_summer[NUM_PHASES];

    utc_local_time_dst_convert_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    utc_local_time_dst_convert_core_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("utc_local_time_dst_convert_core test failed");
        $finish;
    end

    // Seconds since 1970 for a civil date and time of day.
    function automatic longint epoch_seconds(input int yr, input int mon, input int md,
                                             input int hr, input int mi, input int sec);
        longint y;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        y   = (mon <= 2) ? yr - 1 : yr;
        era = y / 400;
        yoe = y - era * 400;
        doy = (153 * ((mon > 2) ? mon - 3 : mon + 9) + 2) / 5 + md - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return (era * 146097 + doe - 719468) * 86400 + hr * 3600 + mi * 60 + sec;
    endfunction

    // Present one request and hold it until the converter takes it.
    task automatic send_request(input logic op, input longint t);
        in_item_t item;
        if (t < 0)
            t = 0;
        if (t > TIME_TOP)
            t = TIME_TOP;
        item.operation  = op;
        item.time_value = t[TIME_BITS-1:0];
        @(negedge clk);
        start   <= 1'b1;
        request <= item;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Leave the request side quiet for a number of cycles.
    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // One register write transfer.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_BITS-1:0];
    endtask

    // Program a full register set; the converter is idle here.
    task automatic program_phase(input logic [1:0] rule, input int std_off,
                                 input int summer_off);
        write_register(REG_DST_RULE, int'(rule));
        write_register(REG_STD_OFFSET, std_off);
        write_register(REG_SUMMER_OFFSET, summer_off);
        @(negedge clk);
        cfg_write <= 1'b0;
        std_now    = std_off;
        summer_now = summer_off;
    endtask

    // The second before a UTC transition hour and the first second of it.
    task automatic send_boundary(input int yr, input int mon, input int md, input int hr);
        longint t;
        t = epoch_seconds(yr, mon, md, hr, 0, 0);
        send_request(OP_TO_LOCAL, t - 1);
        send_request(OP_TO_LOCAL, t);
    endtask

    // One random request, most of them in the transition months.
    task automatic send_random_request();
        int     sel;
        int     mon;
        logic   op;
        longint t;
        sel = $urandom_range(0, 99);
        op  = logic'($urandom_range(0, 1));
        if (sel < 50) begin
            case ($urandom_range(0, 2))
                0:       mon = 3;
                1:       mon = 10;
                default: mon = 11;
            endcase
            t = epoch_seconds($urandom_range(1970, 2500), mon,
                              $urandom_range(1, (mon == 11) ? 30 : 31),
                              $urandom_range(0, 3), $urandom_range(0, 59),
                              $urandom_range(0, 59));
            // Local-time requests carry one of the two offsets.
            if (op == OP_TO_UTC)
                t = t + (($urandom_range(0, 1) == 1) ? std_now : summer_now);
        end else if (sel < 70) begin
            t = {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
        end else if (sel < 85) begin
            if ($urandom_range(0, 1) == 1)
                t = $urandom_range(0, 100000);
            else
                t = TIME_TOP - $urandom_range(0, 100000);
        end else begin
            t = epoch_seconds($urandom_range(1970, 2500), $urandom_range(1, 12),
                              $urandom_range(1, 28), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 59));
        end
        send_request(op, t);
    endtask

    // Stimulus and verdict.
    initial
    begin
        longint edge_times[4];
        int     left;
        int     burst;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        std_now    = 0;
        summer_now = 0;

        // Register settings: directed ones first, the last few random.
        phase_rule[0] = RULE_EU;     phase_std[0] = 3600;    phase_summer[0] = 7200;
        phase_rule[1] = RULE_US;     phase_std[1] = -18000;  phase_summer[1] = -14400;
        phase_rule[2] = RULE_EU;     phase_std[2] = -50400;  phase_summer[2] = 50400;
        phase_rule[3] = RULE_US;     phase_std[3] = 65535;   phase_summer[3] = -65536;
        phase_rule[4] = RULE_UNUSED; phase_std[4] = 50400;   phase_summer[4] = -50400;
        phase_rule[5] = RULE_NONE;   phase_std[5] = -50400;  phase_summer[5] = 50400;
        for (int p = 6; p < NUM_PHASES; p++)
        begin
            phase_rule[p]   = 2'($urandom_range(0, 3));
            phase_std[p]    = $urandom_range(0, 100800) - 50400;
            phase_summer[p] = $urandom_range(0, 100800) - 50400;
        end

        edge_times[0] = 0;
        edge_times[1] = 1;
        edge_times[2] = TIME_TOP - 1;
        edge_times[3] = TIME_TOP;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            program_phase(phase_rule[p], phase_std[p], phase_summer[p]);

            // Directed transfers for this setting.
            if (p == 0) begin
                send_boundary(2024, 3, 31, 1);
                send_boundary(2024, 10, 27, 1);
            end else if (p == 1) begin
                send_boundary(2024, 3, 10, 2);
                send_boundary(2024, 11, 3, 2);
            end else if (p == 2) begin
                foreach (edge_times[i])
                begin
                    send_request(OP_TO_LOCAL, edge_times[i]);
                    send_request(OP_TO_UTC, edge_times[i]);
                end
            end else if (p == 3) begin
                // A write to the unused index must leave the registers alone.
                write_register(REG_SPARE, int'($urandom_range(0, 131071)));
                @(negedge clk);
                cfg_write <= 1'b0;
            end

            // Random bursts with random gaps, sometimes letting the pipe empty.
            left = ITEMS_PHASE;
            while (left > 0)
            begin
                burst = $urandom_range(1, 24);
                if (burst > left)
                    burst = left;
                repeat (burst) send_random_request();
                left = left - burst;
                if ($urandom_range(0, 11) == 0)
                    drain_results();
                else if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 10));
            end
        end

        drain_results();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (fail_count == 0)
            $display("utc_local_time_dst_convert_core test passed");
        else
            $display("utc_local_time_dst_convert_core test failed");
        $finish;
    end

endmodule
